>>> rtl/scanf_format_destination_sizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scanf format destination sizer
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCANF_FORMAT_DESTINATION_SIZER_ASSERT_SVH
`define SCANF_FORMAT_DESTINATION_SIZER_ASSERT_SVH

// Same-cycle implication.
`define SFDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfds assertion failed");

// Next-cycle implication.
`define SFDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfds assertion failed");

`endif

>>> rtl/sfds_pkg.sv
// ----------------------------------------------------------------------------
// sfds_pkg
// Status codes, register indexes, reset values, character codes and character
// classes of the scanf format destination sizer.
// ----------------------------------------------------------------------------
package sfds_pkg;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_ERROR     = 2'd2
    } t_status;

    localparam logic [7:0] REG_TARGET_ARG    = 8'd0;
    localparam logic [7:0] REG_POINTER_BYTES = 8'd1;

    localparam logic [7:0] RST_TARGET_ARG    = 8'd1;
    localparam logic [4:0] RST_POINTER_BYTES = 5'd8;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_BIG_L   = 8'h4C;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_J       = 8'h6A;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_Z       = 8'h7A;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_S       = 8'h73;

    // Integer conversions: d i o u x X n.
    function automatic logic is_int_conv(input logic [7:0] c);
        return (c == 8'h64) || (c == 8'h69) || (c == 8'h6F) || (c == 8'h75) ||
               (c == 8'h78) || (c == 8'h58) || (c == 8'h6E);
    endfunction

    // Floating conversions: a A e E f F g G.
    function automatic logic is_float_conv(input logic [7:0] c);
        return (c == 8'h61) || (c == 8'h41) || (c == 8'h65) || (c == 8'h45) ||
               (c == 8'h66) || (c == 8'h46) || (c == 8'h67) || (c == 8'h47);
    endfunction

endpackage

>>> rtl/scanf_format_destination_sizer.sv
// ----------------------------------------------------------------------------
// scanf_format_destination_sizer
// Parses a scanf format string one byte per transaction and reports the byte
// size of one chosen destination argument.
// ----------------------------------------------------------------------------
// The block takes one format byte per clock cycle on the slave stream, with
// tlast on the final byte of the string, and answers at most once per string
// on the master stream: tuser carries the status (found, not present, or
// malformed) and tdata the destination size in bytes, zero unless found. A
// byte is parsed in the cycle it is accepted, and its answer, if it decides
// one, sits in the output register from the next cycle on. The input is ready
// whenever that register is empty or being taken in the same cycle, so a
// steady stream moves at one byte per cycle; the longest path is the 64-bit
// multiply-by-ten and add of the field width accumulator with its overflow
// check. Once a string is answered, its remaining bytes are accepted and
// dropped up to tlast, and the byte after tlast starts a fresh string. The
// destination number and the pointer size are written on the configuration
// channel, which is always ready; writes should only be made while no string
// is in flight and no answer is pending.
// ----------------------------------------------------------------------------
`include "scanf_format_destination_sizer_assert.svh"

module scanf_format_destination_sizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Format byte stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] format_char
    input  logic        i_s_tlast,   // is_last
    // Answer stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] dest_size
    output logic [1:0]  o_m_tuser,   // [1:0] status
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // Parser phase, one per point in a conversion specification.
    typedef enum logic [3:0] {
        PH_LIT, PH_PCT, PH_WIDTH, PH_LEN, PH_H1, PH_L1,
        PH_CONV, PH_SET0, PH_SET1, PH_SETBODY
    } t_phase;

    // Length modifier seen in the current specification.
    typedef enum logic [3:0] {
        LK_NONE, LK_HH, LK_H, LK_L, LK_LL, LK_J, LK_Z, LK_T, LK_BIGL
    } t_len;

    logic [7:0]  r_target;
    logic [4:0]  r_ptr_bytes;

    t_phase      r_phase, n_phase;
    logic        r_sup, n_sup;
    logic [63:0] r_width, n_width;
    t_len        r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic        r_ans, n_ans;

    logic              r_out_valid;
    sfds_pkg::t_status r_out_status;
    logic [63:0]       r_out_size;

    logic              n_emit;
    sfds_pkg::t_status n_status;
    logic [63:0]       n_size;

    logic        w_in_acc;
    logic [7:0]  w_c;

    assign w_c         = i_s_tdata;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_size;
    assign o_m_tuser   = r_out_status;

    // One byte can fall through several phases, so the phases are written as
    // a chain of tests on a working phase; 'handled' ends the chain.
    always_comb begin
        logic        handled;
        logic        fin;
        logic [7:0]  conv;
        logic [67:0] prod;
        logic [63:0] size;
        logic        is_str;
        logic        bad;

        n_phase  = r_phase;
        n_sup    = r_sup;
        n_width  = r_width;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_ans    = r_ans;
        n_emit   = 1'b0;
        n_status = sfds_pkg::ST_FOUND;
        n_size   = 64'd0;
        handled  = 1'b0;
        fin      = 1'b0;
        conv     = w_c;
        prod     = 68'd0;
        size     = 64'd0;
        is_str   = 1'b0;
        bad      = 1'b0;

        if (!r_ans) begin
            if (n_phase == PH_LIT) begin
                if (w_c == sfds_pkg::CH_PERCENT) begin
                    n_phase = PH_PCT;
                end
                handled = 1'b1;
            end
            if (!handled && n_phase == PH_PCT) begin
                n_sup   = 1'b0;
                n_width = 64'd0;
                n_len   = LK_NONE;
                if (w_c == sfds_pkg::CH_PERCENT) begin
                    n_phase = PH_LIT;
                    handled = 1'b1;
                end else begin
                    n_phase = PH_WIDTH;
                    if (w_c == sfds_pkg::CH_STAR) begin
                        n_sup   = 1'b1;
                        handled = 1'b1;
                    end
                end
            end
            if (!handled && n_phase == PH_WIDTH) begin
                if (w_c >= sfds_pkg::CH_ZERO && w_c <= sfds_pkg::CH_NINE) begin
                    // width * 10 + digit as two shifts and two adds.
                    prod = ({4'd0, n_width} << 3) + ({4'd0, n_width} << 1)
                         + {64'd0, w_c[3:0]};
                    if (prod[67:64] != 4'd0) begin
                        n_ans    = 1'b1;
                        n_emit   = 1'b1;
                        n_status = sfds_pkg::ST_ERROR;
                    end else begin
                        n_width = prod[63:0];
                    end
                    handled = 1'b1;
                end else begin
                    n_phase = PH_LEN;
                end
            end
            if (!handled && n_phase == PH_LEN) begin
                handled = 1'b1;
                if (w_c == sfds_pkg::CH_H) begin
                    n_len = LK_H; n_phase = PH_H1;
                end else if (w_c == sfds_pkg::CH_L) begin
                    n_len = LK_L; n_phase = PH_L1;
                end else if (w_c == sfds_pkg::CH_J) begin
                    n_len = LK_J; n_phase = PH_CONV;
                end else if (w_c == sfds_pkg::CH_Z) begin
                    n_len = LK_Z; n_phase = PH_CONV;
                end else if (w_c == sfds_pkg::CH_T) begin
                    n_len = LK_T; n_phase = PH_CONV;
                end else if (w_c == sfds_pkg::CH_BIG_L) begin
                    n_len = LK_BIGL; n_phase = PH_CONV;
                end else begin
                    handled = 1'b0; n_phase = PH_CONV;
                end
            end
            if (!handled && (n_phase == PH_H1 || n_phase == PH_L1)) begin
                if (n_phase == PH_H1 && w_c == sfds_pkg::CH_H) begin
                    n_len   = LK_HH;
                    handled = 1'b1;
                end else if (n_phase == PH_L1 && w_c == sfds_pkg::CH_L) begin
                    n_len   = LK_LL;
                    handled = 1'b1;
                end
                n_phase = PH_CONV;
            end
            if (!handled && n_phase == PH_CONV) begin
                if (w_c == sfds_pkg::CH_LBRACK) begin
                    n_phase = PH_SET0;
                end else begin
                    fin = 1'b1;
                end
                handled = 1'b1;
            end
            if (!handled && n_phase == PH_SET0) begin
                if (w_c == sfds_pkg::CH_CARET) begin
                    n_phase = PH_SET1;
                    handled = 1'b1;
                end else begin
                    if (w_c == sfds_pkg::CH_RBRACK) begin
                        handled = 1'b1;
                    end
                    n_phase = PH_SETBODY;
                end
            end
            if (!handled && n_phase == PH_SET1) begin
                n_phase = PH_SETBODY;
                if (w_c == sfds_pkg::CH_RBRACK) begin
                    handled = 1'b1;
                end
            end
            if (!handled && n_phase == PH_SETBODY) begin
                if (w_c == sfds_pkg::CH_RBRACK) begin
                    fin  = 1'b1;
                    conv = sfds_pkg::CH_LBRACK;
                end
                handled = 1'b1;
            end
            if (!handled) begin
                n_phase = PH_LIT;
            end

            // End of one conversion specification.
            if (fin) begin
                n_phase = PH_LIT;
                if (!n_sup) begin
                    if (sfds_pkg::is_int_conv(conv)) begin
                        unique case (n_len)
                            LK_HH:   size = 64'd1;
                            LK_H:    size = 64'd2;
                            LK_NONE: size = 64'd4;
                            LK_BIGL: bad  = 1'b1;
                            default: size = 64'd8;
                        endcase
                    end else if (sfds_pkg::is_float_conv(conv)) begin
                        size = (n_len == LK_BIGL) ? 64'd16 :
                               (n_len == LK_L)    ? 64'd8  : 64'd4;
                    end else if (conv == sfds_pkg::CH_P) begin
                        size = {59'd0, r_ptr_bytes};
                    end else if (conv == sfds_pkg::CH_C) begin
                        size = (n_width != 64'd0) ? n_width : 64'd1;
                    end else if (conv == sfds_pkg::CH_S || conv == sfds_pkg::CH_LBRACK) begin
                        bad    = (n_width == 64'd0);
                        is_str = 1'b1;
                        size   = n_width + 64'd1;
                    end else begin
                        bad = 1'b1;
                    end

                    if (bad) begin
                        n_ans    = 1'b1;
                        n_emit   = 1'b1;
                        n_status = sfds_pkg::ST_ERROR;
                    end else if (n_cnt == r_target) begin
                        n_ans  = 1'b1;
                        n_emit = 1'b1;
                        // A string of the widest width has no size that fits.
                        if (is_str && n_width == {64{1'b1}}) begin
                            n_status = sfds_pkg::ST_ERROR;
                        end else begin
                            n_status = sfds_pkg::ST_FOUND;
                            n_size   = size;
                        end
                    end else if (n_cnt != 8'hFF) begin
                        n_cnt = n_cnt + 8'd1;
                    end
                end
            end

            // String ended without a decision.
            if (!n_ans && i_s_tlast) begin
                n_ans    = 1'b1;
                n_emit   = 1'b1;
                n_status = (n_phase == PH_LIT) ? sfds_pkg::ST_NOT_FOUND
                                               : sfds_pkg::ST_ERROR;
            end
        end

        if (i_s_tlast) begin
            n_phase = PH_LIT;
            n_sup   = 1'b0;
            n_width = 64'd0;
            n_len   = LK_NONE;
            n_cnt   = 8'd1;
            n_ans   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= sfds_pkg::RST_TARGET_ARG;
            r_ptr_bytes <= sfds_pkg::RST_POINTER_BYTES;
            r_phase     <= PH_LIT;
            r_sup       <= 1'b0;
            r_width     <= 64'd0;
            r_len       <= LK_NONE;
            r_cnt       <= 8'd1;
            r_ans       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == sfds_pkg::REG_TARGET_ARG) begin
                    r_target <= i_cfg_data;
                end else if (i_cfg_index == sfds_pkg::REG_POINTER_BYTES) begin
                    r_ptr_bytes <= i_cfg_data[4:0];
                end
            end
            if (w_in_acc) begin
                r_phase <= n_phase;
                r_sup   <= n_sup;
                r_width <= n_width;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
                r_ans   <= n_ans;
            end
            if (w_in_acc && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Answer payload, loaded with each new answer.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && n_emit) begin
            r_out_status <= n_status;
            r_out_size   <= n_size;
        end
    end

    // A size is only reported with the found status.
    `SFDS_ASSERT_NOW(a_size_zero_unless_found,
        r_out_valid && r_out_status != sfds_pkg::ST_FOUND, r_out_size == 64'd0)

    // The byte after tlast starts a fresh string.
    `SFDS_ASSERT_NEXT(a_last_clears,
        w_in_acc && i_s_tlast, r_phase == PH_LIT && r_cnt == 8'd1 && !r_ans)

    // An answered string stays answered until its last byte.
    `SFDS_ASSERT_NEXT(a_answer_holds,
        w_in_acc && r_ans && !i_s_tlast, r_ans)

    // An answered string never produces a second answer.
    `SFDS_ASSERT_NOW(a_single_answer, w_in_acc && r_ans, !n_emit)

    // The status code is one of the three defined codes.
    `SFDS_ASSERT_NOW(a_status_code, r_out_valid,
        r_out_status == sfds_pkg::ST_FOUND || r_out_status == sfds_pkg::ST_NOT_FOUND ||
        r_out_status == sfds_pkg::ST_ERROR)

endmodule
